FILE: src/merge_and_insertion_sort_defines.svh
// Assertion macros used by the merge and insertion sort top module.
`ifndef MERGE_AND_INSERTION_SORT_DEFINES_SVH
`define MERGE_AND_INSERTION_SORT_DEFINES_SVH

`ifndef ASSERT_OFF

// Condition must hold at every clock edge outside reset.
`define MAIS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// Antecedent in a cycle implies consequent in the same cycle.
`define MAIS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent in a cycle implies consequent in the following cycle.
`define MAIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MAIS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define MAIS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define MAIS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/mais_pkg.sv
// Types and constants shared by the merge and insertion sort modules.
package mais_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // Broadcast from the controller to every cell of the chain
    typedef struct packed {
        logic                     insert;
        logic                     shift;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctrl;

endpackage

FILE: src/mais_cell.sv
// One compare-and-shift cell of the sorted chain.
module mais_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  mais_pkg::t_cell_ctrl               i_ctrl,
    input  logic                               i_left_gt,
    input  logic                               i_left_valid,
    input  logic signed [mais_pkg::DATA_W-1:0] i_left_value,
    input  logic                               i_right_valid,
    input  logic signed [mais_pkg::DATA_W-1:0] i_right_value,
    output logic                               o_gt,
    output logic                               o_valid,
    output logic signed [mais_pkg::DATA_W-1:0] o_value
);
    import mais_pkg::*;

    logic                     r_valid;
    logic                     n_valid;
    logic signed [DATA_W-1:0] r_value;
    logic signed [DATA_W-1:0] n_value;
    logic                     w_take;

    // Stored value sits strictly above the arriving one: it must move right
    assign o_gt    = r_valid && (r_value > i_ctrl.value);
    assign o_valid = r_valid;
    assign o_value = r_value;

    // Take a new entry if displaced, or if this is the first empty cell
    assign w_take = o_gt || (!r_valid && i_left_valid);

    // Insert shifts larger values right; drain shifts everything left
    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctrl.shift) begin
            n_valid = i_right_valid;
            n_value = i_right_value;
        end else if (i_ctrl.insert && w_take) begin
            n_valid = 1'b1;
            n_value = i_left_gt ? i_left_value : i_ctrl.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

FILE: src/merge_and_insertion_sort.sv
// Merge and insertion sort: a chain of 16 compare-and-shift cells and its controller.
//
// Input stream (s_axis): one signed 32-bit value per request, the first list
// then the second; tlast marks the final value of the combined set. Each
// accepted value is written into the sorted chain by the edge that accepts it, so values
// are taken one per cycle while the block is loading. A value arriving with
// all 16 cells full is dropped and the set is marked as overflowed.
// After the request with tlast is accepted, s_axis_tready falls and the
// chain drains: once the state register has entered drain, the head cell is
// loaded into the output register and m_axis_tvalid rises with the smallest
// value; the rest follow one per cycle while m_axis_tready does not stall,
// ascending, with tlast on the final one and tuser set on every result of an
// overflowed set. The chain shifts towards the output register one cell per
// cycle, so a stall on m_axis_tready holds the chain and the output register
// unchanged. Once the last result is loaded into the output register, tready
// rises again and the next set may start.
// Reset (synchronous, active low) empties the chain, clears the overflow
// flag and the output valid flag; no clearing pass is needed.
module merge_and_insertion_sort (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // [0] overflow
);
    import mais_pkg::*;

`include "merge_and_insertion_sort_defines.svh"

    t_state                   r_state;
    t_state                   n_state;
    logic                     r_dropped;
    logic                     n_dropped;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_last;
    logic                     r_out_ovf;

    t_cell_ctrl               w_ctrl;
    logic                     w_accept;
    logic                     w_full;
    logic                     w_drain_step;
    logic [DEPTH-1:0]         w_valid;
    logic [DEPTH-1:0]         w_gt;
    logic signed [DATA_W-1:0] w_value [DEPTH];

    assign w_accept     = s_axis_tvalid && s_axis_tready;
    assign w_full       = w_valid[DEPTH-1];
    assign w_drain_step = (r_state == ST_DRAIN) && (!r_out_valid || m_axis_tready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_LOAD: begin
                if (w_accept && s_axis_tlast) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_drain_step && !w_valid[1]) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // Controller outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_ctrl.insert = 1'b0;
        w_ctrl.shift  = 1'b0;
        w_ctrl.value  = $signed(s_axis_tdata);
        unique case (r_state)
            ST_LOAD: begin
                s_axis_tready = 1'b1;
                w_ctrl.insert = w_accept && !w_full;
            end
            ST_DRAIN: begin
                w_ctrl.shift = w_drain_step;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Chain of cells, cell 0 holds the smallest value
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                     w_left_gt;
        logic                     w_left_valid;
        logic signed [DATA_W-1:0] w_left_value;
        logic                     w_right_valid;
        logic signed [DATA_W-1:0] w_right_value;

        if (g == 0) begin : g_head
            assign w_left_gt    = 1'b0;
            assign w_left_valid = 1'b1;
            assign w_left_value = w_ctrl.value;
        end else begin : g_body
            assign w_left_gt    = w_gt[g-1];
            assign w_left_valid = w_valid[g-1];
            assign w_left_value = w_value[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right_valid = 1'b0;
            assign w_right_value = '0;
        end else begin : g_mid
            assign w_right_valid = w_valid[g+1];
            assign w_right_value = w_value[g+1];
        end

        mais_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left_gt     (w_left_gt),
            .i_left_valid  (w_left_valid),
            .i_left_value  (w_left_value),
            .i_right_valid (w_right_valid),
            .i_right_value (w_right_value),
            .o_gt          (w_gt[g]),
            .o_valid       (w_valid[g]),
            .o_value       (w_value[g])
        );
    end

    // Overflow flag: set on a dropped request, clear once the set is drained
    always_comb begin
        n_dropped = r_dropped;
        if (w_drain_step && !w_valid[1]) begin
            n_dropped = 1'b0;
        end else if (w_accept && w_full) begin
            n_dropped = 1'b1;
        end
    end

    // Output register valid: load on a drain step, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_drain_step) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload from the head cell
    always_ff @(posedge i_clk) begin
        if (w_drain_step) begin
            r_out_value <= w_value[0];
            r_out_last  <= !w_valid[1];
            r_out_ovf   <= r_dropped;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_value;
    assign m_axis_tlast    = r_out_last;
    assign m_axis_tuser[0] = r_out_ovf;

    // Occupied cells always form a prefix of the chain
    for (genvar a = 1; a < DEPTH; a++) begin : g_chk
        `MAIS_ASSERT_IMPLIES(a_prefix, i_clk, i_rst_n, w_valid[a], w_valid[a-1])
    end

    // A set being drained is never empty at the head
    `MAIS_ASSERT_IMPLIES(a_drain_nonempty, i_clk, i_rst_n, r_state == ST_DRAIN, w_valid[0])

    // An insertion that is not the last of its set grows the occupied prefix by exactly one cell
    `MAIS_ASSERT_NEXT(a_insert_grow, i_clk, i_rst_n, w_ctrl.insert && !s_axis_tlast, $countones(w_valid) == $countones($past(w_valid)) + 1)

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the merge and insertion sort block.
module testbench;
    import mais_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_TAIL  = DEPTH + 8;
    localparam int PHASE_ITEMS = 96;
    localparam int N_DIR_ROWS  = 10;

    // One sorted result as the output stream carries it
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              ovf;
    } t_sorted;

    // Directed row: count requests with values base, base-1, ...; last on the
    // final one; a typed result replaces the prediction for one-value sets
    typedef struct packed {
        logic [DATA_W-1:0] base;
        logic [7:0]        count;
        logic              last;
        logic              typed;
        t_sorted           res;
    } t_dir_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;    // [31:0] value
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;         // [31:0] sorted_value
    logic              m_axis_tlast;
    logic [0:0]        m_axis_tuser;         // [0] overflow

    // Predictor state: the sorted store and its bookkeeping
    logic signed [DATA_W-1:0] sort_store [DEPTH];
    int unsigned              store_fill = 0;
    bit                       store_dropped = 1'b0;
    t_sorted                  pending_sorted [$];

    int          fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    bit          hold_toggle = 1'b0;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;
    t_dir_row    dir_rows [N_DIR_ROWS];

    merge_and_insertion_sort dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Insert one accepted value, stable for equal values; drain on last
    function automatic void sort_in(logic signed [DATA_W-1:0] v, bit last, bit predict);
        int unsigned pos;
        t_sorted     res;
        if (store_fill >= DEPTH) begin
            store_dropped = 1'b1;
        end else begin
            pos = store_fill;
            while (pos > 0 && sort_store[pos-1] > v) begin
                sort_store[pos] = sort_store[pos-1];
                pos--;
            end
            sort_store[pos] = v;
            store_fill++;
        end
        if (last) begin
            if (predict) begin
                for (int k = 0; k < store_fill; k++) begin
                    res.value = sort_store[k];
                    res.last  = (k + 1 == store_fill);
                    res.ovf   = store_dropped;
                    pending_sorted = {pending_sorted, res};
                end
            end
            store_fill    = 0;
            store_dropped = 1'b0;
        end
    endfunction

    // Mostly wide random values, with small values for ties and the extremes
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(4))
            0: v = 32'($signed($urandom_range(16)) - 8);
            1: begin
                case ($urandom_range(3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic offer_item(logic [DATA_W-1:0] v, bit last, bit typed, t_sorted typed_res);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sort_in(v, last, !typed);
        if (typed && last)
            pending_sorted = {pending_sorted, typed_res};
    endtask

    // Drop valid and wait until every predicted result has been taken
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge i_clk);
    endtask

    // Stimulus: directed rows, then random sets under each idling phase
    initial begin
        int unsigned sent;
        int unsigned set_len;
        dir_rows = '{
            '{32'h8000_0000, 8'd1, 1'b1, 1'b1, '{32'h8000_0000, 1'b1, 1'b0}},
            '{32'h7FFF_FFFF, 8'd1, 1'b1, 1'b1, '{32'h7FFF_FFFF, 1'b1, 1'b0}},
            '{32'h0000_0000, 8'd1, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
            '{32'hFFFF_FFFF, 8'd1, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
            '{32'd5,         8'd1, 1'b0, 1'b0, '0},
            '{32'hFFFF_FFFD, 8'd1, 1'b0, 1'b0, '0},
            '{32'd5,         8'd1, 1'b0, 1'b0, '0},
            '{32'h7FFF_FFFF, 8'd1, 1'b0, 1'b0, '0},
            '{32'h8000_0000, 8'd1, 1'b1, 1'b0, '0},
            // Full store: the final value, marked last, is dropped
            '{32'hFFFF_FFF9, 8'd17, 1'b1, 1'b0, '0}
        };
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR_ROWS; r++) begin
            for (int k = 0; k < dir_rows[r].count; k++)
                offer_item(dir_rows[r].base - DATA_W'(k),
                           dir_rows[r].last && (k + 1 == dir_rows[r].count),
                           dir_rows[r].typed, dir_rows[r].res);
        end

        for (int ph = 0; ph < 4; ph++) begin
            // Pause the sender until the receiver has caught up
            wait_results();
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 62; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 62; end
                default: begin tx_idle_pct = 23; rx_stall_pct <= 23; end
            endcase
            // Long receiver hold-off while requests keep coming
            if (ph == 2)
                hold_toggle <= ~hold_toggle;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                set_len = ($urandom_range(9) == 0) ? $urandom_range(DEPTH + 6, DEPTH + 1)
                                                   : $urandom_range(DEPTH, 1);
                for (int k = 0; k < set_len; k++)
                    offer_item(pick_value(), k + 1 == set_len, 1'b0, '0);
                sent += set_len;
            end
        end

        wait_results();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Receiver: random stalls, with a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen     <= hold_toggle;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_sorted exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_sorted.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0d last %0b ovf %0b",
                         $time, $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser[0]);
                fail_count++;
            end else begin
                exp_res = pending_sorted.pop_front();
                if (m_axis_tdata !== exp_res.value) begin
                    $display("%0t: sorted_value mismatch, expected %0d, actual %0d",
                             $time, $signed(exp_res.value), $signed(m_axis_tdata));
                    fail_count++;
                end
                if (m_axis_tlast !== exp_res.last) begin
                    $display("%0t: last_out mismatch, expected %0b, actual %0b",
                             $time, exp_res.last, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tuser[0] !== exp_res.ovf) begin
                    $display("%0t: overflow mismatch, expected %0b, actual %0b",
                             $time, exp_res.ovf, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule

FILE: sim.f
+incdir+src
src/mais_pkg.sv
src/mais_cell.sv
src/merge_and_insertion_sort.sv
tb/testbench.sv
